// ----- hdl/lglg_pkg.sv -----
// ============================================================================
// lglg_pkg
// Shared types and constants for the linear gradient line generator.
// ============================================================================
package lglg_pkg;

  // Largest number of segments one request can produce.
  localparam int MaxSteps = 64;
  // Width of a step index or a saturated extent.
  localparam int ExtW     = $clog2(MaxSteps);
  localparam int CoordW   = 16;
  localparam int ColorW   = 24;
  localparam int ChanW    = 8;
  localparam int NumChan  = 3;

  // Result status codes.
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StClip = 2'd1;
  localparam logic [1:0] StInv  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgFirstColor  = 2'd0;
  localparam logic [1:0] CfgSecondColor = 2'd1;
  localparam logic [1:0] CfgDirection   = 2'd2;

  // Configuration reset values.
  localparam logic [ColorW-1:0] FirstColorRst  = 24'hF0F0F0;
  localparam logic [ColorW-1:0] SecondColorRst = 24'h00003C;
  localparam logic              DirectionRst   = 1'b1;

  // One classified request as it waits in the command queue.
  typedef struct packed {
    logic signed [CoordW-1:0] box_l;
    logic signed [CoordW-1:0] box_t;
    logic signed [CoordW-1:0] box_r;
    logic signed [CoordW-1:0] box_b;
    logic                     dir;
    logic [ExtW-1:0]          ext;
    logic [1:0]               status;
  } cmd_t;

endpackage

// ----- hdl/lglg_front.sv -----
// ============================================================================
// lglg_front
// Request classifier: checks the box for inverted bounds, picks the extent
// along the configured direction and saturates it to the segment limit.
// ============================================================================
module lglg_front (
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [lglg_pkg::CoordW-1:0]   left_edge_i,
  input  logic signed [lglg_pkg::CoordW-1:0]   top_edge_i,
  input  logic signed [lglg_pkg::CoordW-1:0]   right_edge_i,
  input  logic signed [lglg_pkg::CoordW-1:0]   bottom_edge_i,
  input  logic                                 direction_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output lglg_pkg::cmd_t                       cmd_o
);

  localparam int SpanW = lglg_pkg::CoordW + 1;
  localparam logic [SpanW-1:0] ExtMax = SpanW'(lglg_pkg::MaxSteps - 1);

  logic signed [SpanW-1:0] span_x;
  logic signed [SpanW-1:0] span_y;
  logic [SpanW-1:0]        span_sel;
  logic                    inverted;
  logic                    clipped;

  // A beat is taken whenever the queue has room.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Spans are computed one bit wider so they never wrap.
  assign span_x   = {right_edge_i[lglg_pkg::CoordW-1], right_edge_i}
                  - {left_edge_i[lglg_pkg::CoordW-1], left_edge_i};
  assign span_y   = {bottom_edge_i[lglg_pkg::CoordW-1], bottom_edge_i}
                  - {top_edge_i[lglg_pkg::CoordW-1], top_edge_i};
  assign inverted = span_x[SpanW-1] || span_y[SpanW-1];
  assign span_sel = direction_i ? span_y : span_x;
  assign clipped  = span_sel > ExtMax;

  // Build the command for the back end.
  always_comb begin
    cmd_o.box_l  = left_edge_i;
    cmd_o.box_t  = top_edge_i;
    cmd_o.box_r  = right_edge_i;
    cmd_o.box_b  = bottom_edge_i;
    cmd_o.dir    = direction_i;
    if (inverted) begin
      cmd_o.ext    = '0;
      cmd_o.status = lglg_pkg::StInv;
    end else if (clipped) begin
      cmd_o.ext    = ExtMax[lglg_pkg::ExtW-1:0];
      cmd_o.status = lglg_pkg::StClip;
    end else begin
      cmd_o.ext    = span_sel[lglg_pkg::ExtW-1:0];
      cmd_o.status = lglg_pkg::StOk;
    end
  end

endmodule

// ----- hdl/lglg_fifo.sv -----
// ============================================================================
// lglg_fifo
// Two-entry command queue between the classifier and the segment engine.
// ============================================================================
module lglg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lglg_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output lglg_pkg::cmd_t rdata_o,
  output logic           empty_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  lglg_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hdl/lglg_back.sv -----
// ============================================================================
// lglg_back
// Segment engine: for a request of nonzero extent, divides each channel's
// color difference by the extent once, then steps quotient and remainder
// to emit one segment per cycle into an output register whenever it is free.
// ============================================================================
module lglg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lglg_pkg::ColorW-1:0]         first_color_i,
  input  logic [lglg_pkg::ColorW-1:0]         second_color_i,
  input  logic                                cmd_valid_i,
  input  lglg_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_x0_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_y0_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_x1_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_y1_o,
  output logic [lglg_pkg::ColorW-1:0]         seg_color_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  localparam int ExtW  = lglg_pkg::ExtW;
  localparam int ChanW = lglg_pkg::ChanW;
  localparam int NCh   = lglg_pkg::NumChan;
  localparam int CW    = lglg_pkg::CoordW;
  localparam int AccW  = ChanW + 1;
  localparam int CntW  = $clog2(ChanW);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SDiv  = 2'd1;
  localparam logic [1:0] SFix  = 2'd2;
  localparam logic [1:0] SRun  = 2'd3;

  logic [1:0]           state_q, state_d;
  lglg_pkg::cmd_t       cmd_q, cmd_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [ExtW-1:0]      step_q, step_d;

  // Per-channel divider and stepper registers.
  logic [ChanW-1:0]     dvd_q  [NCh];
  logic [ChanW-1:0]     dvd_d  [NCh];
  logic [ChanW-1:0]     quo_q  [NCh];
  logic [ChanW-1:0]     quo_d  [NCh];
  logic [ExtW-1:0]      rem_q  [NCh];
  logic [ExtW-1:0]      rem_d  [NCh];
  logic                 neg_q  [NCh];
  logic                 neg_d  [NCh];
  logic [AccW-1:0]      dq_q   [NCh];
  logic [AccW-1:0]      dq_d   [NCh];
  logic [ExtW-1:0]      dr_q   [NCh];
  logic [ExtW-1:0]      dr_d   [NCh];
  logic [AccW-1:0]      acc_q  [NCh];
  logic [AccW-1:0]      acc_d  [NCh];
  logic [ExtW-1:0]      racc_q [NCh];
  logic [ExtW-1:0]      racc_d [NCh];

  // Combinational helpers.
  logic [AccW-1:0]      diff   [NCh];
  logic [AccW-1:0]      ndiff  [NCh];
  logic [ExtW:0]        trial  [NCh];
  logic [ExtW:0]        rsum   [NCh];
  logic [ChanW-1:0]     chan   [NCh];
  logic [ExtW:0]        ext_w;
  logic [CW-1:0]        step_off;
  logic                 is_last;
  logic                 ld_ok;

  // Output register.
  logic                 vld_q, vld_d;
  logic signed [CW-1:0] x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic [lglg_pkg::ColorW-1:0] col_q, col_d;
  logic [1:0]           st_q, st_d;
  logic                 last_q, last_d;

  assign ext_w     = {1'b0, cmd_q.ext};
  assign step_off  = {{(CW - ExtW){1'b0}}, step_q};
  assign is_last   = step_q == cmd_q.ext;
  assign ld_ok     = !vld_q || out_ready_i;
  assign cmd_pop_o = (state_q == SIdle) && cmd_valid_i;

  // Per-channel difference, restoring-division trial, remainder sum and blended color.
  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      diff[c]  = {1'b0, second_color_i[c*ChanW +: ChanW]}
               - {1'b0, first_color_i[c*ChanW +: ChanW]};
      ndiff[c] = '0 - diff[c];
      trial[c] = {rem_q[c], dvd_q[c][ChanW-1]};
      rsum[c]  = {1'b0, racc_q[c]} + {1'b0, dr_q[c]};
      chan[c]  = first_color_i[c*ChanW +: ChanW] + acc_q[c][ChanW-1:0];
    end
  end

  // Sequencer: fetch, divide and sign fix-up (skipped for zero extent), then one segment per free slot.
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    dq_d    = dq_q;
    dr_d    = dr_q;
    acc_d   = acc_q;
    racc_d  = racc_q;
    vld_d   = vld_q;
    x0_d    = x0_q;
    y0_d    = y0_q;
    x1_d    = x1_q;
    y1_d    = y1_q;
    col_d   = col_q;
    st_d    = st_q;
    last_d  = last_q;

    if (out_ready_i) begin
      vld_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_d  = cmd_i;
          cnt_d  = '0;
          step_d = '0;
          for (int c = 0; c < NCh; c++) begin
            neg_d[c]  = diff[c][AccW-1];
            dvd_d[c]  = diff[c][AccW-1] ? ndiff[c][ChanW-1:0] : diff[c][ChanW-1:0];
            quo_d[c]  = '0;
            rem_d[c]  = '0;
            dq_d[c]   = '0;
            dr_d[c]   = '0;
            acc_d[c]  = '0;
            racc_d[c] = '0;
          end
          state_d = (cmd_i.ext == '0) ? SRun : SDiv;
        end
      end

      SDiv: begin
        // One quotient bit per cycle for each channel.
        for (int c = 0; c < NCh; c++) begin
          dvd_d[c] = {dvd_q[c][ChanW-2:0], 1'b0};
          if (trial[c] >= ext_w) begin
            rem_d[c] = ExtW'(trial[c] - ext_w);
            quo_d[c] = {quo_q[c][ChanW-2:0], 1'b1};
          end else begin
            rem_d[c] = trial[c][ExtW-1:0];
            quo_d[c] = {quo_q[c][ChanW-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ChanW - 1)) begin
          state_d = SFix;
        end
      end

      SFix: begin
        // Turn the magnitude quotient into a floor quotient and remainder.
        for (int c = 0; c < NCh; c++) begin
          if (neg_q[c]) begin
            dq_d[c] = '0 - {1'b0, quo_q[c]} - {{ChanW{1'b0}}, |rem_q[c]};
            dr_d[c] = (|rem_q[c]) ? (cmd_q.ext - rem_q[c]) : '0;
          end else begin
            dq_d[c] = {1'b0, quo_q[c]};
            dr_d[c] = rem_q[c];
          end
        end
        state_d = SRun;
      end

      SRun: begin
        if (ld_ok) begin
          vld_d = 1'b1;
          if (cmd_q.status == lglg_pkg::StInv) begin
            x0_d   = '0;
            y0_d   = '0;
            x1_d   = '0;
            y1_d   = '0;
            col_d  = '0;
            st_d   = lglg_pkg::StInv;
            last_d = 1'b1;
          end else begin
            if (cmd_q.dir) begin
              x0_d = cmd_q.box_l;
              y0_d = cmd_q.box_t + step_off;
              x1_d = cmd_q.box_r;
              y1_d = cmd_q.box_t + step_off;
            end else begin
              x0_d = cmd_q.box_l + step_off;
              y0_d = cmd_q.box_t;
              x1_d = cmd_q.box_l + step_off;
              y1_d = cmd_q.box_b;
            end
            col_d  = {chan[2], chan[1], chan[0]};
            st_d   = cmd_q.status;
            last_d = is_last;
          end

          if (is_last) begin
            state_d = SIdle;
          end else begin
            step_d = step_q + 1'b1;
            for (int c = 0; c < NCh; c++) begin
              if (rsum[c] >= ext_w) begin
                racc_d[c] = ExtW'(rsum[c] - ext_w);
                acc_d[c]  = acc_q[c] + dq_q[c] + AccW'(1);
              end else begin
                racc_d[c] = rsum[c][ExtW-1:0];
                acc_d[c]  = acc_q[c] + dq_q[c];
              end
            end
          end
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      vld_q   <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    dq_q   <= dq_d;
    dr_q   <= dr_d;
    acc_q  <= acc_d;
    racc_q <= racc_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    col_q  <= col_d;
    st_q   <= st_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign seg_x0_o    = x0_q;
  assign seg_y0_o    = y0_q;
  assign seg_x1_o    = x1_q;
  assign seg_y1_o    = y1_q;
  assign seg_color_o = col_q;
  assign status_o    = st_q;
  assign last_o      = last_q;

endmodule

// ----- hdl/linear_gradient_line_generator_top.sv -----
// ============================================================================
// linear_gradient_line_generator_top
// Cuts a fill box into one-pixel line segments with linearly blended colors.
// ============================================================================
// Usage: a request beat on the input channel (valid/ready) carries a box with
// inclusive edges. The output channel (valid/ready) returns one beat per
// column (horizontal) or row (vertical) of the box, up to 64 beats, the final
// one flagged by last_o. Inverted boxes return a single beat with status 2.
// Colors and direction come from the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i). The user must change them only while the block is idle;
// the block itself does not enforce this. Requests pass through a two-entry
// queue, so up to two more requests are taken while one is being emitted.
// The segment engine fetches a request, runs a per-channel restoring
// division of the color difference by the extent and a sign fix-up step,
// then emits one segment per cycle while the output register is free.
// Zero-extent and inverted requests skip the division and the fix-up.
// When the receiver stalls, the output register holds its beat and the
// engine waits. Reset empties the queue, drops any pending output and loads
// the default colors (0xF0F0F0 to 0x00003C) and vertical direction.
// ============================================================================
module linear_gradient_line_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [lglg_pkg::ColorW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lglg_pkg::CoordW-1:0]  left_edge_i,
  input  logic signed [lglg_pkg::CoordW-1:0]  top_edge_i,
  input  logic signed [lglg_pkg::CoordW-1:0]  right_edge_i,
  input  logic signed [lglg_pkg::CoordW-1:0]  bottom_edge_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_x0_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_y0_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_x1_o,
  output logic signed [lglg_pkg::CoordW-1:0]  seg_y1_o,
  output logic [lglg_pkg::ColorW-1:0]         seg_color_o,
  output logic [1:0]                          status_o,
  output logic                                last_o
);

  logic [lglg_pkg::ColorW-1:0] first_color_q;
  logic [lglg_pkg::ColorW-1:0] second_color_q;
  logic                        direction_q;

  logic                        push;
  logic                        full;
  logic                        empty;
  logic                        pop;
  lglg_pkg::cmd_t              push_cmd;
  lglg_pkg::cmd_t              pop_cmd;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_color_q  <= lglg_pkg::FirstColorRst;
      second_color_q <= lglg_pkg::SecondColorRst;
      direction_q    <= lglg_pkg::DirectionRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lglg_pkg::CfgFirstColor:  first_color_q  <= cfg_wdata_i;
        lglg_pkg::CfgSecondColor: second_color_q <= cfg_wdata_i;
        lglg_pkg::CfgDirection:   direction_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Request classification.
  lglg_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .left_edge_i   (left_edge_i),
    .top_edge_i    (top_edge_i),
    .right_edge_i  (right_edge_i),
    .bottom_edge_i (bottom_edge_i),
    .direction_i   (direction_q),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // Command queue.
  lglg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .empty_o (empty)
  );

  // Segment engine.
  lglg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .first_color_i  (first_color_q),
    .second_color_i (second_color_q),
    .cmd_valid_i    (!empty),
    .cmd_i          (pop_cmd),
    .cmd_pop_o      (pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .seg_x0_o       (seg_x0_o),
    .seg_y0_o       (seg_y0_o),
    .seg_x1_o       (seg_x1_o),
    .seg_y1_o       (seg_y1_o),
    .seg_color_o    (seg_color_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// ----- tb/sv/linear_gradient_line_generator_top_tb.sv -----
// ============================================================================
// linear_gradient_line_generator_top_tb
// Self-checking bench for the gradient line generator.
// ============================================================================
// Boxes go in on the request channel and come back as line segments, each with
// a blended color. A predictor built into the bench cuts every accepted box
// into segments and queues them. A checker compares every returned segment
// beat, field by field, against the oldest queued one. Directed boxes cover the
// field extremes, zero extent, clipping and inverted bounds. Several random
// phases follow, each with its own colors and direction. Both handshake sides
// idle at random, with one phase that does not idle at all.
// ============================================================================
module linear_gradient_line_generator_top_tb;

  // Field widths and the segment limit as the block defines them.
  localparam int CoordW   = lglg_pkg::CoordW;
  localparam int ColorW   = lglg_pkg::ColorW;
  localparam int ChanW    = lglg_pkg::ChanW;
  localparam int MaxSteps = lglg_pkg::MaxSteps;

  // Register index that the block does not decode.
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int RandomPhases   = 5;
  localparam int BoxesPerPhase  = 82;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic [ColorW-1:0]        color;
    logic [1:0]               status;
    logic                     last;
  } segment_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [1:0]               cfg_idx_i     = '0;
  logic [ColorW-1:0]        cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] left_edge_i   = '0;
  logic signed [CoordW-1:0] top_edge_i    = '0;
  logic signed [CoordW-1:0] right_edge_i  = '0;
  logic signed [CoordW-1:0] bottom_edge_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i   = 1'b0;
  logic signed [CoordW-1:0] seg_x0_o;
  logic signed [CoordW-1:0] seg_y0_o;
  logic signed [CoordW-1:0] seg_x1_o;
  logic signed [CoordW-1:0] seg_y1_o;
  logic [ColorW-1:0]        seg_color_o;
  logic [1:0]               status_o;
  logic                     last_o;

  // Shadow copy of the color and direction registers.
  logic [ColorW-1:0] shadow_first  = lglg_pkg::FirstColorRst;
  logic [ColorW-1:0] shadow_second = lglg_pkg::SecondColorRst;
  logic              shadow_dir    = lglg_pkg::DirectionRst;

  segment_t predicted_segs[$];
  int       mismatch_cnt = 0;
  bit       tx_idle_on   = 1'b1;
  bit       rx_idle_on   = 1'b1;
  int       rx_stall_left = 0;

  linear_gradient_line_generator_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_edge_i  (left_edge_i),
    .top_edge_i   (top_edge_i),
    .right_edge_i (right_edge_i),
    .bottom_edge_i(bottom_edge_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .seg_x0_o     (seg_x0_o),
    .seg_y0_o     (seg_y0_o),
    .seg_x1_o     (seg_x1_o),
    .seg_y1_o     (seg_y1_o),
    .seg_color_o  (seg_color_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One color channel blended at step i of extent e, with floor division.
  function automatic logic [ChanW-1:0] blend_channel(logic [ChanW-1:0] a,
                                                      logic [ChanW-1:0] b,
                                                      int i, int e);
    int diff;
    int num;
    int quot;
    if (e == 0) return a;
    diff = int'(b) - int'(a);
    num  = diff * i;
    if (num >= 0) quot = num / e;
    else quot = -((-num + e - 1) / e);
    return ChanW'(int'(a) + quot);
  endfunction

  // Cuts one accepted box into its expected segments.
  task automatic predict_segments(input logic signed [CoordW-1:0] l,
                                  input logic signed [CoordW-1:0] t,
                                  input logic signed [CoordW-1:0] r,
                                  input logic signed [CoordW-1:0] b);
    segment_t  seg;
    int        extent;
    logic [1:0] st;
    seg = '0;
    if (r < l || b < t) begin
      seg.status = lglg_pkg::StInv;
      seg.last   = 1'b1;
      predicted_segs.push_back(seg);
      return;
    end
    extent = shadow_dir ? int'(b) - int'(t) : int'(r) - int'(l);
    st = lglg_pkg::StOk;
    if (extent > MaxSteps - 1) begin
      extent = MaxSteps - 1;
      st     = lglg_pkg::StClip;
    end
    for (int i = 0; i <= extent; i++) begin
      seg.color = {blend_channel(shadow_first[23:16], shadow_second[23:16], i, extent),
                   blend_channel(shadow_first[15:8],  shadow_second[15:8],  i, extent),
                   blend_channel(shadow_first[7:0],   shadow_second[7:0],   i, extent)};
      if (shadow_dir) begin
        seg.x0 = l;
        seg.x1 = r;
        seg.y0 = CoordW'(int'(t) + i);
        seg.y1 = CoordW'(int'(t) + i);
      end else begin
        seg.x0 = CoordW'(int'(l) + i);
        seg.x1 = CoordW'(int'(l) + i);
        seg.y0 = t;
        seg.y1 = b;
      end
      seg.status = st;
      seg.last   = (i == extent);
      predicted_segs.push_back(seg);
    end
  endtask

  // Presents one box and waits for its beat to be taken.
  task automatic send_box(input logic signed [CoordW-1:0] l,
                          input logic signed [CoordW-1:0] t,
                          input logic signed [CoordW-1:0] r,
                          input logic signed [CoordW-1:0] b);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    left_edge_i   <= l;
    top_edge_i    <= t;
    right_edge_i  <= r;
    bottom_edge_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_segments(l, t, r, b);
  endtask

  // Stops sending and waits until every predicted segment has come back.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (predicted_segs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it in the shadow copy.
  task automatic write_reg(input logic [1:0] idx, input logic [ColorW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lglg_pkg::CfgFirstColor:  shadow_first  = data;
      lglg_pkg::CfgSecondColor: shadow_second = data;
      lglg_pkg::CfgDirection:   shadow_dir    = data[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Places a span of width w at a random base without leaving the field range.
  task automatic place_span(input int w, output logic signed [CoordW-1:0] lo,
                            output logic signed [CoordW-1:0] hi);
    int base;
    base = int'($urandom_range(0, 65535)) - 32768;
    if (base + w > 32767) base = 32767 - w;
    lo = CoordW'(base);
    hi = CoordW'(base + w);
  endtask

  // Extent along the gradient: mostly short, some long, some clipped.
  function automatic int pick_extent();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(0, 15);
    if (roll < 78) return $urandom_range(16, 62);
    if (roll < 84) return MaxSteps - 1;
    if (roll < 92) return $urandom_range(MaxSteps, 200);
    return $urandom_range(MaxSteps, 65535);
  endfunction

  // Random box; a small share is inverted along one axis or the other.
  task automatic make_random_box(output logic signed [CoordW-1:0] l,
                                 output logic signed [CoordW-1:0] t,
                                 output logic signed [CoordW-1:0] r,
                                 output logic signed [CoordW-1:0] b);
    int                       roll;
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
    logic signed [CoordW-1:0] olo;
    logic signed [CoordW-1:0] ohi;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      place_span($urandom_range(1, 65535), hi, lo);
      place_span($urandom_range(0, 65535), olo, ohi);
    end else if (roll < 12) begin
      place_span(pick_extent(), lo, hi);
      place_span($urandom_range(1, 65535), ohi, olo);
    end else begin
      place_span(pick_extent(), lo, hi);
      place_span($urandom_range(0, 65535), olo, ohi);
    end
    if (shadow_dir) begin
      t = lo; b = hi; l = olo; r = ohi;
    end else begin
      l = lo; r = hi; t = olo; b = ohi;
    end
  endtask

  // Receiver side: stalls of random length, or none while idling is off.
  always @(posedge clk_i) begin
    int n;
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready_i   <= 1'b0;
    end else begin
      n = rx_idle_on ? pick_gap() : 0;
      if (n > 0) begin
        rx_stall_left <= n - 1;
        out_ready_i   <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic report_if_diff(input string name, input logic [ColorW-1:0] want,
                                input logic [ColorW-1:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endtask

  // Every segment beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    segment_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_segs.size() == 0) begin
        mismatch_cnt++;
        $error("segment beat with none predicted: x0 %0d y0 %0d", seg_x0_o, seg_y0_o);
      end else begin
        want = predicted_segs.pop_front();
        report_if_diff("seg_x0", want.x0, seg_x0_o);
        report_if_diff("seg_y0", want.y0, seg_y0_o);
        report_if_diff("seg_x1", want.x1, seg_x1_o);
        report_if_diff("seg_y1", want.y1, seg_y1_o);
        report_if_diff("seg_color", want.color, seg_color_o);
        report_if_diff("status", want.status, status_o);
        report_if_diff("last", want.last, last_o);
      end
    end
  end

  // Reset colors, vertical: zero extent, the clip boundary, inverted boxes
  // and coordinates at the ends of the field range.
  task automatic test_reset_config();
    send_box(10, 20, 10, 20);
    send_box(-5, 100, 7, 101);
    send_box(0, -32768, 0, -32705);
    send_box(3, 0, 3, 64);
    send_box(-32768, -32768, 32767, 32767);
    send_box(5, 0, 4, 10);
    send_box(0, 10, 0, 9);
    send_box(32767, 32767, -32768, -32768);
    send_box(-32768, 32767, -32768, 32767);
    send_box(32767, 32704, 32767, 32767);
    wait_for_drain();
  endtask

  // Horizontal with full-scale color ramps both ways, equal colors, and a
  // write to an undecoded index that must change nothing.
  task automatic test_horizontal_ramps();
    write_reg(lglg_pkg::CfgDirection, 24'hFFFFFE);
    write_reg(lglg_pkg::CfgFirstColor, 24'h000000);
    write_reg(lglg_pkg::CfgSecondColor, 24'hFFFFFF);
    send_box(0, 0, 0, 0);
    send_box(-2, 7, 1, 9);
    send_box(32704, -32768, 32767, 32767);
    send_box(-32768, 0, -32704, 0);
    send_box(1, 0, 0, 0);
    wait_for_drain();
    write_reg(lglg_pkg::CfgFirstColor, 24'hFFFFFF);
    write_reg(lglg_pkg::CfgSecondColor, 24'h000000);
    write_reg(CfgUnused, 24'($urandom));
    send_box(100, -3, 107, 3);
    send_box(-1, -1, 0, -1);
    wait_for_drain();
    write_reg(lglg_pkg::CfgSecondColor, 24'hFFFFFF);
    send_box(-40, 0, -35, 12);
    wait_for_drain();
  endtask

  // Random boxes over several register settings, with an occasional pause
  // until all segments are back.
  task automatic test_random_traffic();
    logic signed [CoordW-1:0] l;
    logic signed [CoordW-1:0] t;
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] b;
    for (int p = 0; p < RandomPhases; p++) begin
      wait_for_drain();
      case (p)
        0: begin
          write_reg(lglg_pkg::CfgFirstColor, 24'h000000);
          write_reg(lglg_pkg::CfgSecondColor, 24'hFFFFFF);
        end
        1: begin
          write_reg(lglg_pkg::CfgFirstColor, 24'hFFFFFF);
          write_reg(lglg_pkg::CfgSecondColor, 24'h000000);
        end
        default: begin
          write_reg(lglg_pkg::CfgFirstColor, 24'($urandom));
          write_reg(lglg_pkg::CfgSecondColor, 24'($urandom));
        end
      endcase
      write_reg(lglg_pkg::CfgDirection, {23'($urandom), 1'(p % 2)});
      tx_idle_on = (p != 2);
      rx_idle_on = (p != 2);
      for (int k = 0; k < BoxesPerPhase; k++) begin
        if ($urandom_range(0, 99) < 2) wait_for_drain();
        make_random_box(l, t, r, b);
        send_box(l, t, r, b);
      end
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_reset_config();
    test_horizontal_ramps();
    test_random_traffic();
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
